>>> design/tssm_pkg.sv
// Package for the two-stack shared-memory block: request and status codes,
// controller/datapath command and status structs. No dependencies.
package tssm_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int WORD_W     = 32;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int S_USER_W   = MODE_W;
    localparam int M_USER_W   = STATUS_W + 1;

    localparam logic [MODE_W-1:0] MODE_PUSH_A = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_B = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_A  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_B  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIST   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

    // what the latched request needs from the sequencer
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_READ = 2'd2
    } req_kind_t;

    typedef struct packed {
        logic take;
        logic exec;
        logic step;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        req_kind_t kind;
        logic      slot_free;
        logic      pend_last;
    } dp_stat_t;

endpackage

>>> design/two_stacks_shared_memory_top.sv
// Top level of the two-stack shared-memory block: sequencer plus datapath.
// Depends on tssm_pkg, tssm_ctrl and tssm_dp.
//
// Two LIFO stacks share one DEPTH-word memory, A growing up from word 0 and B
// down from word DEPTH-1. One request is handled at a time. A push, a refused
// request or an unused mode is taken and then executed or dropped before the next
// beat can be accepted; a pop adds a load of the read word into the output register;
// a list reads and loads its words one at a time, bounded by the single-port
// memory with its registered read and the one-beat output register (each word
// is read, then loaded into that register). Memory is not cleared at reset,
// so the block is ready right after reset. Output stalls can delay these steps.
module two_stacks_shared_memory_top #(
    parameter int DEPTH = tssm_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tssm_pkg::WORD_W-1:0]     s_tdata,   // [31:0] push_value
    input  logic [tssm_pkg::S_USER_W-1:0]   s_tuser,   // [2:0] mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tssm_pkg::WORD_W-1:0]     m_tdata,   // [31:0] data_out
    output logic [tssm_pkg::M_USER_W-1:0]   m_tuser,   // [1:0] status, [2] from_b
    output logic                            m_tlast
);
    import tssm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tssm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tssm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> design/tssm_ctrl.sv
// Sequencer for the two-stack block: accepts a request, runs it through the
// datapath and walks list requests. Depends on tssm_pkg.
module tssm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tssm_pkg::dp_stat_t stat,
    output tssm_pkg::dp_cmd_t  cmd
);
    import tssm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_RD   = 4'b0100,
        S_WALK = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.kind == KIND_NONE) begin
                    state_next = S_IDLE;
                end else if (stat.slot_free) begin
                    cmd.exec   = 1'b1;
                    state_next = (stat.kind == KIND_READ) ? S_RD : S_IDLE;
                end
            end
            S_RD: begin
                cmd.load   = 1'b1;
                state_next = stat.pend_last ? S_IDLE : S_WALK;
            end
            S_WALK: begin
                if (stat.slot_free) begin
                    cmd.step   = 1'b1;
                    state_next = S_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_rd_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && stat.kind == KIND_READ) || cmd.step |=> cmd.load)
        else $error("read issued without a load next cycle");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |=> !s_tready)
        else $error("second request taken while one is open");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.take, cmd.exec, cmd.step, cmd.load}))
        else $error("overlapping datapath commands");
`endif

endmodule

>>> design/tssm_dp.sv
// Datapath for the two-stack block: shared word memory, stack counts, list
// walk pointer and output register. Depends on tssm_pkg.
module tssm_dp #(
    parameter int DEPTH = tssm_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tssm_pkg::dp_cmd_t               cmd,
    output tssm_pkg::dp_stat_t              stat,
    input  logic [tssm_pkg::WORD_W-1:0]     s_tdata,
    input  logic [tssm_pkg::S_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tssm_pkg::WORD_W-1:0]     m_tdata,
    output logic [tssm_pkg::M_USER_W-1:0]   m_tuser,
    output logic                            m_tlast
);
    import tssm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [MODE_W-1:0]   mode_reg;
    logic [WORD_W-1:0]   value_reg;
    logic [CW-1:0]       count_a_reg, count_a_next;
    logic [CW-1:0]       count_b_reg, count_b_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic                phase_b_reg, phase_b_next;
    logic                pend_b_reg, pend_b_next;
    logic                pend_last_reg, pend_last_next;
    logic [WORD_W-1:0]   rdata_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [WORD_W-1:0]   out_data_reg;
    logic                out_from_b_reg;
    logic                out_last_reg;

    logic                full, a_empty, b_empty;
    logic [AW-1:0]       top_a, free_b, base_b;
    logic                wr_en, rd_en, out_load, out_from_b;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [STATUS_W-1:0] out_status;
    req_kind_t           kind;

    assign full    = ({1'b0, count_a_reg} + {1'b0, count_b_reg}) >= (CW + 1)'(DEPTH);
    assign a_empty = (count_a_reg == '0);
    assign b_empty = (count_b_reg == '0);
    assign top_a   = AW'(count_a_reg - CW'(1));
    assign free_b  = AW'(CW'(DEPTH - 1) - count_b_reg);
    assign base_b  = AW'(CW'(DEPTH) - count_b_reg);

    always_comb begin
        unique case (mode_reg)
            MODE_PUSH_A, MODE_PUSH_B: kind = KIND_DONE;
            MODE_POP_A, MODE_LIST:    kind = a_empty ? KIND_DONE : KIND_READ;
            MODE_POP_B:               kind = b_empty ? KIND_DONE : KIND_READ;
            default:                  kind = KIND_NONE;
        endcase
    end

    always_comb begin
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        ptr_next       = ptr_reg;
        phase_b_next   = phase_b_reg;
        pend_b_next    = pend_b_reg;
        pend_last_next = pend_last_reg;
        wr_en          = 1'b0;
        wr_addr        = AW'(count_a_reg);
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;
        out_load       = 1'b0;
        out_status     = STAT_OK;
        out_from_b     = 1'b0;
        if (cmd.exec) begin
            unique case (mode_reg)
                MODE_PUSH_A: begin
                    out_load = 1'b1;
                    if (full) begin
                        out_status = STAT_OVERFLOW;
                    end else begin
                        wr_en        = 1'b1;
                        count_a_next = count_a_reg + CW'(1);
                    end
                end
                MODE_PUSH_B: begin
                    out_load   = 1'b1;
                    out_from_b = 1'b1;
                    wr_addr    = free_b;
                    if (full) begin
                        out_status = STAT_OVERFLOW;
                    end else begin
                        wr_en        = 1'b1;
                        count_b_next = count_b_reg + CW'(1);
                    end
                end
                MODE_POP_A: begin
                    if (a_empty) begin
                        out_load   = 1'b1;
                        out_status = STAT_UNDERFLOW;
                    end else begin
                        count_a_next   = count_a_reg - CW'(1);
                        rd_en          = 1'b1;
                        rd_addr        = top_a;
                        pend_b_next    = 1'b0;
                        pend_last_next = 1'b1;
                    end
                end
                MODE_POP_B: begin
                    out_from_b = 1'b1;
                    if (b_empty) begin
                        out_load   = 1'b1;
                        out_status = STAT_UNDERFLOW;
                    end else begin
                        count_b_next   = count_b_reg - CW'(1);
                        rd_en          = 1'b1;
                        rd_addr        = base_b;
                        pend_b_next    = 1'b1;
                        pend_last_next = 1'b1;
                    end
                end
                MODE_LIST: begin
                    if (a_empty) begin
                        out_load   = 1'b1;
                        out_status = STAT_UNDERFLOW;
                    end else begin
                        rd_en          = 1'b1;
                        rd_addr        = top_a;
                        ptr_next       = top_a;
                        phase_b_next   = 1'b0;
                        pend_b_next    = 1'b0;
                        pend_last_next = (count_a_reg == CW'(1)) && b_empty;
                    end
                end
                default: ;
            endcase
        end else if (cmd.step) begin
            rd_en = 1'b1;
            if (!phase_b_reg && ptr_reg == '0) begin
                // A exhausted, continue at B's top
                rd_addr        = base_b;
                phase_b_next   = 1'b1;
                pend_last_next = (base_b == AW'(DEPTH - 1));
            end else if (!phase_b_reg) begin
                rd_addr        = ptr_reg - AW'(1);
                pend_last_next = (rd_addr == '0) && b_empty;
            end else begin
                rd_addr        = ptr_reg + AW'(1);
                pend_last_next = (rd_addr == AW'(DEPTH - 1));
            end
            ptr_next    = rd_addr;
            pend_b_next = phase_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            mode_reg  <= s_tuser;
            value_reg <= s_tdata;
        end
        if (wr_en) begin
            mem[wr_addr] <= value_reg;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        ptr_reg       <= ptr_next;
        phase_b_reg   <= phase_b_next;
        pend_b_reg    <= pend_b_next;
        pend_last_reg <= pend_last_next;
        if (out_load) begin
            out_status_reg <= out_status;
            out_data_reg   <= '0;
            out_from_b_reg <= out_from_b;
            out_last_reg   <= 1'b1;
        end else if (cmd.load) begin
            out_status_reg <= STAT_OK;
            out_data_reg   <= rdata_reg;
            out_from_b_reg <= pend_b_reg;
            out_last_reg   <= pend_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            if (out_load || cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.kind      = kind;
    assign stat.slot_free = !out_valid_reg || m_tready;
    assign stat.pend_last = pend_last_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_from_b_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, count_a_reg} + {1'b0, count_b_reg}) <= (CW + 1)'(DEPTH))
        else $error("stack counts exceed memory depth");
    a_load_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !out_valid_reg)
        else $error("read word loaded over a pending beat");
    a_exec_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec || cmd.step) |-> (!out_valid_reg || m_tready))
        else $error("request executed while output slot busy");
`endif

endmodule

>>> tb/two_stacks_checker.sv
`timescale 1ns / 1ps
// Checker for two_stacks_shared_memory_top: watches both stream channels and
// predicts results from a shadow copy of the two stacks. Depends on tssm_pkg.
module two_stacks_checker #(
    parameter int DEPTH = tssm_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [tssm_pkg::WORD_W-1:0]     s_tdata,
    input  logic [tssm_pkg::S_USER_W-1:0]   s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tssm_pkg::WORD_W-1:0]     m_tdata,
    input  logic [tssm_pkg::M_USER_W-1:0]   m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              results_pending
);
    import tssm_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   data;
        logic                from_b;
        logic                last;
    } stack_beat_t;

    logic [WORD_W-1:0] shadow_mem [DEPTH];
    int                depth_a;
    int                depth_b;
    stack_beat_t       expected_beats [$];
    int                mismatches;

    function automatic stack_beat_t make_beat(input logic [STATUS_W-1:0] status,
                                              input logic [WORD_W-1:0] data,
                                              input logic from_b, input logic last);
        stack_beat_t b;
        b.status = status;
        b.data   = data;
        b.from_b = from_b;
        b.last   = last;
        return b;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic predict_request(input logic [MODE_W-1:0] mode,
                                   input logic [WORD_W-1:0] value);
        bit full;
        int i;
        full = (depth_a + depth_b) >= DEPTH;
        case (mode)
            MODE_PUSH_A: begin
                if (full) begin
                    expected_beats.push_back(make_beat(STAT_OVERFLOW, '0, 1'b0, 1'b1));
                end else begin
                    shadow_mem[depth_a] = value;
                    depth_a++;
                    expected_beats.push_back(make_beat(STAT_OK, '0, 1'b0, 1'b1));
                end
            end
            MODE_PUSH_B: begin
                if (full) begin
                    expected_beats.push_back(make_beat(STAT_OVERFLOW, '0, 1'b1, 1'b1));
                end else begin
                    shadow_mem[DEPTH-1-depth_b] = value;
                    depth_b++;
                    expected_beats.push_back(make_beat(STAT_OK, '0, 1'b1, 1'b1));
                end
            end
            MODE_POP_A: begin
                if (depth_a == 0) begin
                    expected_beats.push_back(make_beat(STAT_UNDERFLOW, '0, 1'b0, 1'b1));
                end else begin
                    depth_a--;
                    expected_beats.push_back(make_beat(STAT_OK, shadow_mem[depth_a],
                                                       1'b0, 1'b1));
                end
            end
            MODE_POP_B: begin
                if (depth_b == 0) begin
                    expected_beats.push_back(make_beat(STAT_UNDERFLOW, '0, 1'b1, 1'b1));
                end else begin
                    depth_b--;
                    expected_beats.push_back(make_beat(STAT_OK, shadow_mem[DEPTH-1-depth_b],
                                                       1'b1, 1'b1));
                end
            end
            MODE_LIST: begin
                if (depth_a == 0) begin
                    expected_beats.push_back(make_beat(STAT_UNDERFLOW, '0, 1'b0, 1'b1));
                end else begin
                    for (i = depth_a - 1; i >= 0; i--)
                        expected_beats.push_back(make_beat(STAT_OK, shadow_mem[i], 1'b0,
                                                           (i == 0) && (depth_b == 0)));
                    for (i = DEPTH - depth_b; i < DEPTH; i++)
                        expected_beats.push_back(make_beat(STAT_OK, shadow_mem[i], 1'b1,
                                                           i == DEPTH - 1));
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        stack_beat_t got;
        stack_beat_t want;
        if (!aresetn) begin
            depth_a = 0;
            depth_b = 0;
            mismatches = 0;
            expected_beats.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                got = make_beat(m_tuser[STATUS_W-1:0], m_tdata, m_tuser[STATUS_W], m_tlast);
                if (expected_beats.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat status=%0d data=%h b=%0d last=%0d",
                                            got.status, got.data, got.from_b, got.last));
                end else begin
                    want = expected_beats.pop_front();
                    if (got.status !== want.status || got.data !== want.data ||
                        got.from_b !== want.from_b || got.last !== want.last)
                        note_mismatch($sformatf({"exp status=%0d data=%h b=%0d last=%0d, ",
                                                 "got status=%0d data=%h b=%0d last=%0d"},
                                                want.status, want.data, want.from_b,
                                                want.last, got.status, got.data,
                                                got.from_b, got.last));
                end
            end
        end
        fail_count      <= mismatches;
        results_pending <= expected_beats.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for two_stacks_shared_memory_top: clock, reset, request
// stimulus and output backpressure. Depends on tssm_pkg and two_stacks_checker.
module testbench;
    import tssm_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;
    localparam int PHASE_FILL  = 0;
    localparam int PHASE_DRAIN = 1;
    localparam int PHASE_MIXED = 2;
    localparam int RANDOM_REQS = 420;
    localparam int LONG_HOLD   = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata;
    logic [S_USER_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [WORD_W-1:0]     m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  m_tlast;
    int                    fail_count;
    int                    results_pending;
    bit                    long_hold_go;
    int                    quiet_left;

    two_stacks_shared_memory_top #(.DEPTH(DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    two_stacks_checker #(.DEPTH(DEPTH)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .fail_count(fail_count), .results_pending(results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("testbench: FAIL");
        $finish;
    end

    // mostly short gaps, a few long ones, and quiet stretches with none
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if (r < 3)
            quiet_left = $urandom_range(20, 40);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return 32'h8000_0000;
        if (r < 8)  return 32'h7FFF_FFFF;
        if (r < 12) return 32'hFFFF_FFFF;
        if (r < 16) return '0;
        return $urandom;
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input int phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PHASE_FILL: begin
                if (r < 35) return MODE_PUSH_A;
                if (r < 70) return MODE_PUSH_B;
                if (r < 78) return MODE_POP_A;
                if (r < 86) return MODE_POP_B;
                if (r < 96) return MODE_LIST;
            end
            PHASE_DRAIN: begin
                if (r < 8)  return MODE_PUSH_A;
                if (r < 16) return MODE_PUSH_B;
                if (r < 50) return MODE_POP_A;
                if (r < 84) return MODE_POP_B;
                if (r < 95) return MODE_LIST;
            end
            default: begin
                if (r < 20) return MODE_PUSH_A;
                if (r < 40) return MODE_PUSH_B;
                if (r < 60) return MODE_POP_A;
                if (r < 80) return MODE_POP_B;
                if (r < 95) return MODE_LIST;
            end
        endcase
        return MODE_W'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
    endfunction

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (results_pending != 0) @(negedge aclk);
    endtask

    // output backpressure, including one long hold-off
    initial begin
        int stall;
        bit held;
        m_tready = 1'b0;
        held = 1'b0;
        while (!aresetn) @(negedge aclk);
        forever begin
            if (long_hold_go && !held) begin
                held = 1'b1;
                stall = LONG_HOLD;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7: stall = 0;
                    8, 9, 10, 11, 12, 13, 14, 15: stall = $urandom_range(1, 3);
                    16, 17: stall = $urandom_range(4, 12);
                    default: stall = $urandom_range(20, 30);
                endcase
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(30, 60)) @(negedge aclk);
            else
                repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    end

    initial begin
        int sent;
        int phase;
        int phase_left;
        logic [MODE_W-1:0] mode;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        long_hold_go = 1'b0;
        quiet_left   = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty stacks, list with only B holding words, extremes, unused modes
        send_request(MODE_LIST, 32'h1234_5678);
        send_request(MODE_POP_A, '0);
        send_request(MODE_POP_B, 32'hFFFF_FFFF);
        send_request(MODE_PUSH_B, 32'h7FFF_FFFF);
        send_request(MODE_LIST, '0);
        send_request(MODE_PUSH_A, 32'h8000_0000);
        send_request(MODE_PUSH_A, 32'hFFFF_FFFF);
        send_request(MODE_PUSH_A, '0);
        send_request(MODE_PUSH_B, 32'h8000_0000);
        send_request(MODE_LIST, '0);
        for (int m = MODE_RSVD_LO; m <= MODE_RSVD_HI; m++)
            send_request(MODE_W'(m), 32'hFFFF_FFFF);
        send_request(MODE_POP_B, '0);
        send_request(MODE_POP_B, '0);
        send_request(MODE_LIST, '0);
        send_request(MODE_POP_A, '0);
        send_request(MODE_POP_A, '0);
        send_request(MODE_POP_A, '0);
        send_request(MODE_POP_A, '0);
        send_request(MODE_PUSH_B, 32'h5555_5555);
        send_request(MODE_PUSH_A, 32'hAAAA_AAAA);
        send_request(MODE_LIST, '0);
        wait_drained();

        sent = 0;
        phase = PHASE_FILL;
        phase_left = $urandom_range(20, 40);
        while (sent < RANDOM_REQS) begin
            if (phase_left == 0) begin
                phase = $urandom_range(PHASE_FILL, PHASE_MIXED);
                phase_left = $urandom_range(20, 40);
            end
            mode = pick_mode(phase);
            send_request(mode, pick_value());
            if (mode <= MODE_LIST) begin
                sent++;
                phase_left--;
                if (sent == 150)
                    long_hold_go <= 1'b1;
                if (sent == 300)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (40) @(negedge aclk);
        if (fail_count == 0 && results_pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
